// ----- src/three_wire_register_access_master_macros.svh -----
// ----------------------------------------------------------------------------
// Three-wire register access master: assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_REGISTER_ACCESS_MASTER_MACROS_SVH
`define THREE_WIRE_REGISTER_ACCESS_MASTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWRA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/twra_pkg.sv -----
// ----------------------------------------------------------------------------
// Three-wire register access master: package
// Shared types, phase codes, command codes and register indexes.
// ----------------------------------------------------------------------------
package twra_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic REG_SETUP_TICKS = 1'b0;
    localparam logic REG_PHASE_TICKS = 1'b1;

    localparam logic [7:0] SETUP_TICKS_RESET = 8'd4;
    localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SETUP = 3'd1;
    localparam logic [2:0] PH_WLOW  = 3'd2;
    localparam logic [2:0] PH_WDATA = 3'd3;
    localparam logic [2:0] PH_WHIGH = 3'd4;
    localparam logic [2:0] PH_RHIGH = 3'd5;
    localparam logic [2:0] PH_RLOW  = 3'd6;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] bit_index;
        logic       byte_index;
        logic [7:0] tick_count;
        logic       is_read;
        logic [7:0] command_byte;
        logic [7:0] data_byte;
        logic [7:0] shift_in;
        logic       ce;
        logic       clk;
        logic       io;
        logic       drive;
    } twra_state_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
    } twra_result_t;

    function automatic logic [7:0] hold_count(input logic [7:0] n);
        hold_count = (n == 8'd0) ? 8'd1 : n;
    endfunction

endpackage

// ----- src/three_wire_register_access_master.sv -----
// ----------------------------------------------------------------------------
// Three-wire register access master: top level
// Tick-driven master for a chip-enable, clock and bidirectional-data bus.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one bus tick and may start a read or a
// write; a start given while a transaction runs is ignored. Every request
// gives exactly one result on the m_ channel carrying the pin levels after
// that tick, the busy flag, the last read byte and the completion strobes.
// Bits go least significant first.
// The tick is worked out combinationally by the sequencer between its state
// register and the result register, so a result appears in the cycle after its
// request is taken, and one request is taken in every cycle unless the receiver stalls.
// The result register lets a new request in while the held result is being
// taken; while the receiver stalls with a result held, s_ready is low.
// Reset empties the result register, idles the bus with all pins low and
// the data line driven, and loads the timing registers with their defaults.
// The timing registers are written through cfg_we, cfg_index and cfg_wdata
// and should only be changed while no transaction is in progress.
// ----------------------------------------------------------------------------
module three_wire_register_access_master (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [7:0] s_address,
    input  logic [7:0] s_write_data,
    input  logic       s_io_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_chip_enable,
    output logic       m_serial_clock,
    output logic       m_io_out,
    output logic       m_io_drive,
    output logic       m_busy_res,
    output logic [7:0] m_read_data,
    output logic       m_read_valid,
    output logic       m_done_res
);
    import twra_pkg::*;

    logic [7:0]   setup_ticks_reg;
    logic [7:0]   phase_ticks_reg;
    logic         m_valid_reg;
    twra_result_t res_reg;
    twra_result_t res_next;
    logic         accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_ticks_reg <= SETUP_TICKS_RESET;
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_SETUP_TICKS) begin
                setup_ticks_reg <= cfg_wdata;
            end else begin
                phase_ticks_reg <= cfg_wdata;
            end
        end
    end

    twra_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .command     (s_command),
        .address     (s_address),
        .write_data  (s_write_data),
        .io_in       (s_io_in),
        .setup_ticks (setup_ticks_reg),
        .phase_ticks (phase_ticks_reg),
        .result      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_chip_enable  = res_reg.chip_enable;
    assign m_serial_clock = res_reg.serial_clock;
    assign m_io_out       = res_reg.io_out;
    assign m_io_drive     = res_reg.io_drive;
    assign m_busy_res     = res_reg.busy_res;
    assign m_read_data    = res_reg.read_data;
    assign m_read_valid   = res_reg.read_valid;
    assign m_done_res     = res_reg.done_res;

endmodule

// ----- src/twra_seq.sv -----
// ----------------------------------------------------------------------------
// Three-wire register access master: bus sequencer
// Holds the bus state and advances it by one tick per accepted request.
// ----------------------------------------------------------------------------
module twra_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [1:0]           command,
    input  logic [7:0]           address,
    input  logic [7:0]           write_data,
    input  logic                 io_in,
    input  logic [7:0]           setup_ticks,
    input  logic [7:0]           phase_ticks,
    output twra_pkg::twra_result_t result
);
    import twra_pkg::*;

    twra_state_t st_reg;
    twra_state_t st_next;
    logic        done;
    logic        rvalid;
    logic [7:0]  cur_byte;

    assign cur_byte = st_reg.byte_index ? st_reg.data_byte : st_reg.command_byte;

    always_comb begin
        st_next = st_reg;
        done    = 1'b0;
        rvalid  = 1'b0;
        if (st_reg.phase == PH_IDLE) begin
            if (command inside {CMD_READ, CMD_WRITE}) begin
                st_next.is_read      = (command == CMD_READ);
                st_next.command_byte = (command == CMD_READ) ? 8'(address + 8'd1) : address;
                st_next.data_byte    = (command == CMD_READ) ? 8'd0 : write_data;
                st_next.bit_index    = 3'd0;
                st_next.byte_index   = 1'b0;
                st_next.ce           = 1'b1;
                st_next.phase        = PH_SETUP;
                st_next.tick_count   = hold_count(setup_ticks);
            end
        end else if (st_reg.tick_count > 8'd1) begin
            st_next.tick_count = st_reg.tick_count - 8'd1;
        end else begin
            st_next.tick_count = hold_count(phase_ticks);
            case (st_reg.phase)
                PH_SETUP: begin
                    st_next.clk   = 1'b0;
                    st_next.drive = 1'b1;
                    st_next.phase = PH_WLOW;
                end
                PH_WLOW: begin
                    st_next.io    = cur_byte[st_reg.bit_index];
                    st_next.phase = PH_WDATA;
                end
                PH_WDATA: begin
                    st_next.clk   = 1'b1;
                    st_next.phase = PH_WHIGH;
                end
                PH_WHIGH: begin
                    if (st_reg.bit_index != LAST_BIT) begin
                        st_next.bit_index = st_reg.bit_index + 3'd1;
                        st_next.clk       = 1'b0;
                        st_next.drive     = 1'b1;
                        st_next.phase     = PH_WLOW;
                    end else if (st_reg.is_read) begin
                        st_next.bit_index = 3'd0;
                        st_next.drive     = 1'b0;
                        st_next.clk       = 1'b1;
                        st_next.phase     = PH_RHIGH;
                    end else if (!st_reg.byte_index) begin
                        st_next.byte_index = 1'b1;
                        st_next.bit_index  = 3'd0;
                        st_next.clk        = 1'b0;
                        st_next.drive      = 1'b1;
                        st_next.phase      = PH_WLOW;
                    end else begin
                        st_next.ce         = 1'b0;
                        st_next.phase      = PH_IDLE;
                        st_next.tick_count = 8'd0;
                        done               = 1'b1;
                    end
                end
                PH_RHIGH: begin
                    st_next.clk   = 1'b0;
                    st_next.phase = PH_RLOW;
                end
                PH_RLOW: begin
                    st_next.data_byte = {io_in, st_reg.data_byte[7:1]};
                    if (st_reg.bit_index != LAST_BIT) begin
                        st_next.bit_index = st_reg.bit_index + 3'd1;
                        st_next.clk       = 1'b1;
                        st_next.phase     = PH_RHIGH;
                    end else begin
                        st_next.shift_in   = {io_in, st_reg.data_byte[7:1]};
                        st_next.ce         = 1'b0;
                        st_next.phase      = PH_IDLE;
                        st_next.tick_count = 8'd0;
                        rvalid             = 1'b1;
                        done               = 1'b1;
                    end
                end
                default: begin
                    st_next.phase      = PH_IDLE;
                    st_next.tick_count = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{phase: PH_IDLE, drive: 1'b1, default: '0};
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    assign result.chip_enable  = st_next.ce;
    assign result.serial_clock = st_next.clk;
    assign result.io_out       = st_next.io;
    assign result.io_drive     = st_next.drive;
    assign result.busy_res     = (st_next.phase != PH_IDLE);
    assign result.read_data    = st_next.shift_in;
    assign result.read_valid   = rvalid;
    assign result.done_res     = done;

endmodule

// ----- src/twra_checker.sv -----
// ----------------------------------------------------------------------------
// Three-wire register access master: port checker
// Watches the result channel of the top level and checks its consistency.
// ----------------------------------------------------------------------------
`include "three_wire_register_access_master_macros.svh"

module twra_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_chip_enable,
    input logic       m_serial_clock,
    input logic       m_io_out,
    input logic       m_io_drive,
    input logic       m_busy_res,
    input logic [7:0] m_read_data,
    input logic       m_read_valid,
    input logic       m_done_res
);

    logic [14:0] held_result;
    logic        read_end;

    assign held_result = {m_chip_enable, m_serial_clock, m_io_out, m_io_drive, m_busy_res,
                          m_read_data, m_read_valid, m_done_res};
    assign read_end    = m_done_res && !m_io_drive;

    `TWRA_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(held_result), "stalled result changed")
    `TWRA_ASSERT_SAME(a_busy_is_enable, m_valid, m_busy_res == m_chip_enable, "busy and enable differ")
    `TWRA_ASSERT_SAME(a_done_idle, m_valid && m_done_res, !m_busy_res && !m_chip_enable, "busy at end")
    `TWRA_ASSERT_SAME(a_read_ends, m_valid && m_read_valid, read_end, "read ended while driving")

endmodule

bind three_wire_register_access_master twra_checker u_twra_checker (.*);

// ----- sim/three_wire_register_access_master_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire register access master: regression testbench
// Drives bus ticks on the request channel with random gaps and back-pressure,
// predicts the pin levels and strobes of every tick, and compares each result.
// ----------------------------------------------------------------------------
module three_wire_register_access_master_test;
    import twra_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int IO_LOW = 0;
    localparam int IO_HIGH = 1;
    localparam int IO_RANDOM = 2;
    localparam int PRESSURE_HOLD = 300;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_command;
    logic [7:0] s_address;
    logic [7:0] s_write_data;
    logic       s_io_in;
    logic       m_valid;
    logic       m_ready;
    logic       m_chip_enable;
    logic       m_serial_clock;
    logic       m_io_out;
    logic       m_io_drive;
    logic       m_busy_res;
    logic [7:0] m_read_data;
    logic       m_read_valid;
    logic       m_done_res;

    twra_state_t  bus;
    logic [7:0]   setup_len;
    logic [7:0]   phase_len;
    twra_result_t predicted_pins[$];

    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned ticks_sent;
    int unsigned writes_started;
    int unsigned reads_started;
    int unsigned settings_applied;
    int unsigned sender_calm;
    bit          sender_eager;
    bit          hold_off_request;

    three_wire_register_access_master dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_address      (s_address),
        .s_write_data   (s_write_data),
        .s_io_in        (s_io_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chip_enable  (m_chip_enable),
        .m_serial_clock (m_serial_clock),
        .m_io_out       (m_io_out),
        .m_io_drive     (m_io_drive),
        .m_busy_res     (m_busy_res),
        .m_read_data    (m_read_data),
        .m_read_valid   (m_read_valid),
        .m_done_res     (m_done_res)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void begin_phase(input logic [2:0] next_phase, input logic [7:0] hold);
        bus.phase = next_phase;
        bus.tick_count = (hold == 8'd0) ? 8'd1 : hold;
    endfunction

    function automatic twra_result_t advance_bus(input logic [1:0] cmd, input logic [7:0] addr,
            input logic [7:0] wdata, input logic io);
        twra_result_t r;
        logic [7:0]   sending;
        r = '0;
        if (bus.phase == PH_IDLE) begin
            if (cmd == CMD_READ || cmd == CMD_WRITE) begin
                bus.is_read = (cmd == CMD_READ);
                bus.command_byte = (cmd == CMD_READ) ? addr + 8'd1 : addr;
                bus.data_byte = (cmd == CMD_READ) ? 8'd0 : wdata;
                bus.bit_index = '0;
                bus.byte_index = 1'b0;
                bus.ce = 1'b1;
                begin_phase(PH_SETUP, setup_len);
                if (cmd == CMD_READ) reads_started++;
                else writes_started++;
            end
        end else if (bus.tick_count > 8'd1) begin
            bus.tick_count = bus.tick_count - 8'd1;
        end else begin
            case (bus.phase)
                PH_SETUP: begin
                    bus.clk = 1'b0;
                    bus.drive = 1'b1;
                    begin_phase(PH_WLOW, phase_len);
                end
                PH_WLOW: begin
                    sending = bus.byte_index ? bus.data_byte : bus.command_byte;
                    bus.io = sending[bus.bit_index];
                    begin_phase(PH_WDATA, phase_len);
                end
                PH_WDATA: begin
                    bus.clk = 1'b1;
                    begin_phase(PH_WHIGH, phase_len);
                end
                PH_WHIGH: begin
                    if (bus.bit_index != LAST_BIT) begin
                        bus.bit_index = bus.bit_index + 3'd1;
                        bus.clk = 1'b0;
                        bus.drive = 1'b1;
                        begin_phase(PH_WLOW, phase_len);
                    end else if (bus.is_read) begin
                        bus.bit_index = '0;
                        bus.drive = 1'b0;
                        bus.clk = 1'b1;
                        begin_phase(PH_RHIGH, phase_len);
                    end else if (!bus.byte_index) begin
                        bus.byte_index = 1'b1;
                        bus.bit_index = '0;
                        bus.clk = 1'b0;
                        bus.drive = 1'b1;
                        begin_phase(PH_WLOW, phase_len);
                    end else begin
                        bus.ce = 1'b0;
                        r.done_res = 1'b1;
                        bus.phase = PH_IDLE;
                        bus.tick_count = 8'd0;
                    end
                end
                PH_RHIGH: begin
                    bus.clk = 1'b0;
                    begin_phase(PH_RLOW, phase_len);
                end
                PH_RLOW: begin
                    bus.data_byte = {io, bus.data_byte[7:1]};
                    if (bus.bit_index != LAST_BIT) begin
                        bus.bit_index = bus.bit_index + 3'd1;
                        bus.clk = 1'b1;
                        begin_phase(PH_RHIGH, phase_len);
                    end else begin
                        bus.shift_in = bus.data_byte;
                        bus.ce = 1'b0;
                        r.read_valid = 1'b1;
                        r.done_res = 1'b1;
                        bus.phase = PH_IDLE;
                        bus.tick_count = 8'd0;
                    end
                end
                default: begin
                    bus.phase = PH_IDLE;
                    bus.tick_count = 8'd0;
                end
            endcase
        end
        r.chip_enable = bus.ce;
        r.serial_clock = bus.clk;
        r.io_out = bus.io;
        r.io_drive = bus.drive;
        r.busy_res = (bus.phase != PH_IDLE);
        r.read_data = bus.shift_in;
        return r;
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] addr,
            input logic [7:0] wdata, input logic io);
        int unsigned gap;
        gap = (sender_calm > 0 || sender_eager) ? 0 : draw_gap();
        if (sender_calm > 0) sender_calm--;
        else if ($urandom_range(0, 49) == 0) sender_calm = $urandom_range(20, 120);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_command = cmd;
        s_address = addr;
        s_write_data = wdata;
        s_io_in = io;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted_pins.push_back(advance_bus(cmd, addr, wdata, io));
        ticks_sent++;
    endtask

    task automatic sender_rest();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_for_results();
        sender_rest();
        while (predicted_pins.size() != 0) @(posedge aclk);
    endtask

    task automatic finish_transaction(input int io_mode, input bit noisy);
        logic [1:0] cmd;
        logic       io;
        while (bus.phase != PH_IDLE) begin
            cmd = noisy ? 2'($urandom_range(0, 3)) : CMD_TICK;
            case (io_mode)
                IO_LOW: io = 1'b0;
                IO_HIGH: io = 1'b1;
                default: io = 1'($urandom);
            endcase
            send_request(cmd, 8'($urandom), 8'($urandom), io);
        end
    endtask

    task automatic run_transaction(input logic [1:0] cmd, input logic [7:0] addr,
            input logic [7:0] wdata, input int io_mode, input bit noisy);
        send_request(cmd, addr, wdata, 1'($urandom));
        finish_transaction(io_mode, noisy);
    endtask

    task automatic set_register(input logic idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_SETUP_TICKS) setup_len = value;
        else phase_len = value;
    endtask

    task automatic apply_timing(input logic [7:0] setup_value, input logic [7:0] phase_value);
        finish_transaction(IO_RANDOM, 1'b0);
        wait_for_results();
        set_register(REG_SETUP_TICKS, setup_value);
        set_register(REG_PHASE_TICKS, phase_value);
        settings_applied++;
    endtask

    task automatic send_random_request();
        logic [1:0] cmd;
        if (bus.phase == PH_IDLE) begin
            if ($urandom_range(0, 9) < 6) cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
            else cmd = $urandom_range(0, 1) ? CMD_TICK : CMD_SPARE;
        end else begin
            cmd = ($urandom_range(0, 9) < 8) ? CMD_TICK : 2'($urandom_range(0, 3));
        end
        send_request(cmd, 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic test_idle_ticks();
        send_request(CMD_TICK, 8'hFF, 8'hFF, 1'b1);
        send_request(CMD_SPARE, 8'h00, 8'h00, 1'b0);
        send_request(CMD_TICK, 8'h00, 8'hFF, 1'b0);
        send_request(CMD_SPARE, 8'hFF, 8'h00, 1'b1);
    endtask

    task automatic test_directed_transactions();
        run_transaction(CMD_WRITE, 8'h00, 8'hFF, IO_RANDOM, 1'b0);
        run_transaction(CMD_WRITE, 8'hFF, 8'h00, IO_RANDOM, 1'b1);
        run_transaction(CMD_READ, 8'hFF, 8'h00, IO_HIGH, 1'b0);
        run_transaction(CMD_READ, 8'h7F, 8'hA5, IO_LOW, 1'b1);
        run_transaction(CMD_READ, 8'h00, 8'hFF, IO_RANDOM, 1'b0);
        run_transaction(CMD_WRITE, 8'hA5, 8'h5A, IO_RANDOM, 1'b1);
    endtask

    task automatic test_timing_extremes();
        apply_timing(8'd1, 8'd1);
        run_transaction(CMD_WRITE, 8'h3C, 8'hC3, IO_RANDOM, 1'b1);
        run_transaction(CMD_READ, 8'h80, 8'h00, IO_RANDOM, 1'b0);
        // A zero in either timing register behaves as a hold of one tick.
        apply_timing(8'd0, 8'd0);
        run_transaction(CMD_READ, 8'h01, 8'h00, IO_RANDOM, 1'b1);
        run_transaction(CMD_WRITE, 8'h96, 8'h69, IO_RANDOM, 1'b0);
        apply_timing(8'd40, 8'd1);
        run_transaction(CMD_WRITE, 8'h5A, 8'hA5, IO_RANDOM, 1'b1);
        apply_timing(8'd1, 8'd2);
        run_transaction(CMD_READ, 8'hE7, 8'h00, IO_RANDOM, 1'b1);
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < 2; k++) begin
            apply_timing(8'($urandom_range(1, 6)), 8'($urandom_range(1, 3)));
            for (int i = 0; i < 40; i++) send_random_request();
        end
        finish_transaction(IO_RANDOM, 1'b1);
    endtask

    task automatic test_output_backpressure();
        sender_eager = 1'b1;
        hold_off_request = 1'b1;
        for (int i = 0; i < 40; i++) send_random_request();
        sender_eager = 1'b0;
        finish_transaction(IO_RANDOM, 1'b1);
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        int unsigned calm_left;
        m_ready = 1'b0;
        stall_left = 0;
        calm_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall_left = PRESSURE_HOLD;
            end else if (stall_left == 0) begin
                if (calm_left > 0) calm_left--;
                else if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(20, 120);
                else if ($urandom_range(0, 3) == 0) stall_left = draw_gap();
            end
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic compare_field(input string field, input logic [7:0] want,
            input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        twra_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_pins.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatches++;
            end else begin
                want = predicted_pins.pop_front();
                compare_field("chip_enable", 8'(want.chip_enable), 8'(m_chip_enable));
                compare_field("serial_clock", 8'(want.serial_clock), 8'(m_serial_clock));
                compare_field("io_out", 8'(want.io_out), 8'(m_io_out));
                compare_field("io_drive", 8'(want.io_drive), 8'(m_io_drive));
                compare_field("busy_res", 8'(want.busy_res), 8'(m_busy_res));
                compare_field("read_data", want.read_data, m_read_data);
                compare_field("read_valid", 8'(want.read_valid), 8'(m_read_valid));
                compare_field("done_res", 8'(want.done_res), 8'(m_done_res));
                results_checked++;
            end
        end
    end

    initial begin : watchdog
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = 8'd0;
        s_valid = 1'b0;
        s_command = CMD_TICK;
        s_address = 8'd0;
        s_write_data = 8'd0;
        s_io_in = 1'b0;
        bus = '0;
        bus.phase = PH_IDLE;
        bus.drive = 1'b1;
        setup_len = SETUP_TICKS_RESET;
        phase_len = PHASE_TICKS_RESET;
        mismatches = 0;
        results_checked = 0;
        ticks_sent = 0;
        writes_started = 0;
        reads_started = 0;
        settings_applied = 0;
        sender_calm = 0;
        sender_eager = 1'b0;
        hold_off_request = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        test_idle_ticks();
        test_directed_transactions();
        test_timing_extremes();
        test_random_traffic();
        test_output_backpressure();

        wait_for_results();
        repeat (4) @(posedge aclk);
        $display("Sent %0d ticks: %0d writes, %0d reads, %0d timing settings.",
                 ticks_sent, writes_started, reads_started, settings_applied);
        $display("Compared %0d results field by field, including one long output stall.",
                 results_checked);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
